// File: rtl/core/jsc_pkg.sv
// ----------------------------------------------------------------------------
// jsc_pkg
// Shared types and constants for the JSON structure checker: character
// classes, the classified queue entry and the key/value phase codes.
// ----------------------------------------------------------------------------
package jsc_pkg;

  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_BSLASH,
    CLS_QUOTE,
    CLS_SPACE,
    CLS_LBRACK,
    CLS_RBRACK,
    CLS_LBRACE,
    CLS_RBRACE,
    CLS_COLON,
    CLS_COMMA
  } char_class_e;

  localparam logic [1:0] PH_NONE      = 2'd0;
  localparam logic [1:0] PH_KEY       = 2'd1;
  localparam logic [1:0] PH_KEY_COLON = 2'd2;
  localparam logic [1:0] PH_PAIR      = 2'd3;

  localparam logic [1:0] BC_SAT = 2'd2;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    char_class_e cls;
    logic        starts_value;
    logic        last;
    logic        obj_mode;
  } item_t;

endpackage

// File: rtl/core/json_structure_checker.sv
// ----------------------------------------------------------------------------
// json_structure_checker
// Streaming structure check of a JSON message, one byte per transaction, with
// one verdict transaction per message.
// ----------------------------------------------------------------------------
//  channel   direction  tdata / data                tlast / extra
//  s_axis    in         [7:0] data_byte             tlast = last
//  m_axis    out        [0] valid_res, [7:1] zero   -
//  cfg       in         [0] object_mode             -
//
//  One byte per cycle while the queue has room; after its last byte is taken,
//  a verdict passes through the queue entry, then the output register.
//  The two-entry queue between classifier and state update decouples the
//  input from a stalled result; only a last byte waits on m_axis in the back end.
//  Reset returns all control state to idle (array depth 1) and sets object_mode to 0.
// ----------------------------------------------------------------------------
module json_structure_checker import jsc_pkg::*; #(
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] valid_res, [7:1] zero
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i      // [0] object_mode
);

  logic  obj_mode_q;
  logic  item_valid, item_ready;
  item_t item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      obj_mode_q <= cfg_data_i;
    end
  end

  jsc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .obj_mode_i    (obj_mode_q),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready),
    .item_o        (item)
  );

  jsc_back #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .item_i        (item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: rtl/core/jsc_front.sv
// ----------------------------------------------------------------------------
// jsc_front
// Accept input bytes, classify each one and hold it in a short queue for the
// back end.
// ----------------------------------------------------------------------------
module jsc_front import jsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  logic       s_axis_tlast,
  input  logic       obj_mode_i,
  output logic       item_valid_o,
  input  logic       item_ready_i,
  output item_t      item_o
);

  item_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]  cnt_q;
  item_t                 cls_item;
  logic                  push, pop;

  always_comb begin
    cls_item.cls = CLS_OTHER;
    unique case (s_axis_tdata)
      8'h5C:               cls_item.cls = CLS_BSLASH;
      8'h22:               cls_item.cls = CLS_QUOTE;
      8'h20, 8'h0A, 8'h09: cls_item.cls = CLS_SPACE;
      8'h5B:               cls_item.cls = CLS_LBRACK;
      8'h5D:               cls_item.cls = CLS_RBRACK;
      8'h7B:               cls_item.cls = CLS_LBRACE;
      8'h7D:               cls_item.cls = CLS_RBRACE;
      8'h3A:               cls_item.cls = CLS_COLON;
      8'h2C:               cls_item.cls = CLS_COMMA;
      default:             cls_item.cls = CLS_OTHER;
    endcase
    cls_item.starts_value = (s_axis_tdata >= 8'h30 && s_axis_tdata <= 8'h39) ||
                            s_axis_tdata == 8'h74 || s_axis_tdata == 8'h66 ||
                            s_axis_tdata == 8'h6E || s_axis_tdata == 8'h5B ||
                            s_axis_tdata == 8'h7B;
    cls_item.last     = s_axis_tlast;
    cls_item.obj_mode = obj_mode_i;
  end

  assign s_axis_tready = (cnt_q != QueueCntW'(QueueDepth));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid_o  = (cnt_q != '0);
  assign pop           = item_valid_o && item_ready_i;
  assign item_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/core/jsc_back.sv
// ----------------------------------------------------------------------------
// jsc_back
// Update the string, nesting and key/value state for each classified byte and
// register the verdict on the last byte of a message.
// ----------------------------------------------------------------------------
module jsc_back import jsc_pkg::*; #(
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  output logic       item_ready_o,
  input  item_t      item_i,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] valid_res, [7:1] zero
);

  logic [DEPTH_BITS-1:0] ad_q, ad_d, od_q, od_d, oq_q, oq_d;
  logic                  ins_q, ins_d, esc_q, esc_d, seen_q, seen_d;
  logic                  pclose_q, pclose_d, fault_q, fault_d;
  logic [1:0]            ph_q, ph_d, bc_q, bc_d;
  logic                  out_valid_q, res_q, res_d;
  logic                  take;

  assign item_ready_o  = !item_i.last || !out_valid_q || m_axis_tready;
  assign take          = item_valid_i && item_ready_o;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, res_q};

  always_comb begin
    ad_d     = ad_q;
    od_d     = od_q;
    oq_d     = oq_q;
    ins_d    = ins_q;
    esc_d    = esc_q;
    seen_d   = seen_q;
    pclose_d = (item_i.cls == CLS_RBRACK) || (item_i.cls == CLS_RBRACE);
    fault_d  = fault_q;
    ph_d     = ph_q;
    bc_d     = (bc_q == BC_SAT) ? BC_SAT : bc_q + 2'd1;
    if (bc_q == '0) begin
      ad_d = item_i.obj_mode ? '0 : DEPTH_BITS'(1);
      od_d = item_i.obj_mode ? DEPTH_BITS'(1) : '0;
    end
    priority if (item_i.cls == CLS_BSLASH && !esc_q) begin
      esc_d = 1'b1;
    end else if (item_i.cls == CLS_QUOTE && !esc_q) begin
      ins_d = !ins_q;
      esc_d = 1'b0;
      if (!ins_q) begin
        oq_d   = oq_q + 1'b1;
        seen_d = 1'b1;
      end else begin
        oq_d = oq_q - 1'b1;
      end
    end else if (esc_q) begin
      esc_d = 1'b0;
    end else if (!ins_q) begin
      if (item_i.cls == CLS_SPACE) begin
        pclose_d = pclose_q;
      end else begin
        if (seen_q) begin
          ph_d   = (ph_q == PH_KEY_COLON) ? PH_PAIR : PH_KEY;
          seen_d = 1'b0;
        end else if (ph_q == PH_KEY_COLON && item_i.starts_value) begin
          ph_d = PH_PAIR;
        end
        unique case (item_i.cls)
          CLS_LBRACK: ad_d = ad_d + 1'b1;
          CLS_RBRACK: ad_d = ad_d - 1'b1;
          CLS_LBRACE: begin
            od_d = od_d + 1'b1;
            if (ph_d != PH_NONE && ph_d != PH_PAIR) fault_d = 1'b1;
          end
          CLS_RBRACE: od_d = od_d - 1'b1;
          CLS_COLON: begin
            if (ph_d != PH_KEY) fault_d = 1'b1;
            ph_d = PH_KEY_COLON;
          end
          CLS_COMMA: begin
            if (!pclose_q) begin
              if (ph_d == PH_KEY_COLON) fault_d = 1'b1;
              ph_d = PH_NONE;
            end
          end
          default: ;
        endcase
      end
    end else begin
      esc_d = esc_q;
    end
    res_d = (bc_d == BC_SAT) && !fault_d && (ad_d == '0) && (od_d == '0) && (oq_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.last) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ad_q        <= DEPTH_BITS'(1);
      od_q        <= '0;
      oq_q        <= '0;
      ins_q       <= 1'b0;
      esc_q       <= 1'b0;
      seen_q      <= 1'b0;
      pclose_q    <= 1'b0;
      fault_q     <= 1'b0;
      ph_q        <= PH_NONE;
      bc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (take && item_i.last) || (out_valid_q && !m_axis_tready);
      if (take) begin
        if (item_i.last) begin
          ad_q     <= DEPTH_BITS'(1);
          od_q     <= '0;
          oq_q     <= '0;
          ins_q    <= 1'b0;
          esc_q    <= 1'b0;
          seen_q   <= 1'b0;
          pclose_q <= 1'b0;
          fault_q  <= 1'b0;
          ph_q     <= PH_NONE;
          bc_q     <= '0;
        end else begin
          ad_q     <= ad_d;
          od_q     <= od_d;
          oq_q     <= oq_d;
          ins_q    <= ins_d;
          esc_q    <= esc_d;
          seen_q   <= seen_d;
          pclose_q <= pclose_d;
          fault_q  <= fault_d;
          ph_q     <= ph_d;
          bc_q     <= bc_d;
        end
      end
    end
  end

endmodule
